/* hw/rtl/owbm_pkg.sv */
package owbm_pkg;

  // operation codes of an input item
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_RESET = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // sequencer phases
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_RST_LOW  = 3'd1;
  localparam logic [2:0] PH_RST_WAIT = 3'd2;
  localparam logic [2:0] PH_RST_TAIL = 3'd3;
  localparam logic [2:0] PH_SLOT     = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_RESET_LOW       = 3'd0;
  localparam logic [2:0] REG_PRESENCE_SAMPLE = 3'd1;
  localparam logic [2:0] REG_RESET_TAIL      = 3'd2;
  localparam logic [2:0] REG_SHORT_LOW       = 3'd3;
  localparam logic [2:0] REG_LONG_LOW        = 3'd4;
  localparam logic [2:0] REG_READ_SAMPLE     = 3'd5;
  localparam logic [2:0] REG_SLOT_LENGTH     = 3'd6;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // power-up timing values in microseconds
  localparam logic [9:0] RST_RESET_LOW       = 10'd480;
  localparam logic [9:0] RST_PRESENCE_SAMPLE = 10'd70;
  localparam logic [9:0] RST_RESET_TAIL      = 10'd410;
  localparam logic [7:0] RST_SHORT_LOW       = 8'd6;
  localparam logic [7:0] RST_LONG_LOW        = 8'd60;
  localparam logic [7:0] RST_READ_SAMPLE     = 8'd15;
  localparam logic [7:0] RST_SLOT_LENGTH     = 8'd70;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
    logic       line_level;
  } owbm_in_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       rejected;
  } owbm_out_t;

  typedef struct packed {
    logic [9:0] reset_low_us;
    logic [9:0] presence_sample_us;
    logic [9:0] reset_tail_us;
    logic [7:0] short_low_us;
    logic [7:0] long_low_us;
    logic [7:0] read_sample_us;
    logic [7:0] slot_length_us;
  } owbm_cfg_t;

endpackage

/* hw/rtl/owbm_cfg.sv */
module owbm_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 wr_en,
  input  logic [owbm_pkg::CFG_IDX_W-1:0]       wr_index,
  input  logic [owbm_pkg::CFG_DATA_W-1:0]      wr_data,
  output owbm_pkg::owbm_cfg_t                  cfg
);
  import owbm_pkg::*;

  owbm_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_us       <= RST_RESET_LOW;
      cfg_r.presence_sample_us <= RST_PRESENCE_SAMPLE;
      cfg_r.reset_tail_us      <= RST_RESET_TAIL;
      cfg_r.short_low_us       <= RST_SHORT_LOW;
      cfg_r.long_low_us        <= RST_LONG_LOW;
      cfg_r.read_sample_us     <= RST_READ_SAMPLE;
      cfg_r.slot_length_us     <= RST_SLOT_LENGTH;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RESET_LOW:       cfg_r.reset_low_us       <= wr_data;
        REG_PRESENCE_SAMPLE: cfg_r.presence_sample_us <= wr_data;
        REG_RESET_TAIL:      cfg_r.reset_tail_us      <= wr_data;
        REG_SHORT_LOW:       cfg_r.short_low_us       <= wr_data[7:0];
        REG_LONG_LOW:        cfg_r.long_low_us        <= wr_data[7:0];
        REG_READ_SAMPLE:     cfg_r.read_sample_us     <= wr_data[7:0];
        REG_SLOT_LENGTH:     cfg_r.slot_length_us     <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/owbm_core.sv */
module owbm_core #(
  parameter int unsigned COUNT_WIDTH = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  owbm_pkg::owbm_in_t   item,
  input  owbm_pkg::owbm_cfg_t  cfg,
  output owbm_pkg::owbm_out_t  result
);
  import owbm_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > 10) ? COUNT_WIDTH : 10;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [2:0]             phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [3:0]             bits_r, bits_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic                   reading_r, reading_nxt;
  logic                   presence_r, presence_nxt;
  logic                   drive_r, drive_nxt;
  logic [7:0]             rdval_r, rdval_nxt;
  logic                   done;
  logic                   rej;

  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [CMP_W-1:0]       cnt_ext;
  logic                   cnt_sat;
  logic [7:0]             low_len;
  logic                   slot_end;
  logic [7:0]             shift_smp;
  logic [3:0]             bits_dec;

  assign cnt_inc  = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign cnt_ext  = CMP_W'(cnt_inc);
  assign cnt_sat  = (cnt_inc == CNT_MAX);
  assign low_len  = (reading_r || shift_r[0]) ? cfg.short_low_us : cfg.long_low_us;
  assign slot_end = (cnt_ext >= CMP_W'(cfg.slot_length_us)) || cnt_sat;
  assign bits_dec = bits_r - 4'd1;

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    bits_nxt     = bits_r;
    shift_nxt    = shift_r;
    reading_nxt  = reading_r;
    presence_nxt = presence_r;
    drive_nxt    = drive_r;
    rdval_nxt    = rdval_r;
    done         = 1'b0;
    rej          = 1'b0;
    shift_smp    = shift_r;

    if (item.op == OP_TICK) begin
      if (phase_r == PH_IDLE) begin
        drive_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_inc;
        unique case (phase_r)
          PH_RST_LOW: begin
            if ((cnt_ext >= CMP_W'(cfg.reset_low_us)) || cnt_sat) begin
              drive_nxt = 1'b0;
              cnt_nxt   = '0;
              phase_nxt = PH_RST_WAIT;
            end
          end
          PH_RST_WAIT: begin
            if ((cnt_ext >= CMP_W'(cfg.presence_sample_us)) || cnt_sat) begin
              presence_nxt = ~item.line_level;
              cnt_nxt      = '0;
              phase_nxt    = PH_RST_TAIL;
            end
          end
          PH_RST_TAIL: begin
            if ((cnt_ext >= CMP_W'(cfg.reset_tail_us)) || cnt_sat) begin
              phase_nxt = PH_IDLE;
              cnt_nxt   = '0;
              done      = 1'b1;
            end
          end
          default: begin
            drive_nxt = (cnt_ext < CMP_W'(low_len));
            // late sample point falls back to the slot end
            if (reading_r && ((cnt_ext == CMP_W'(cfg.read_sample_us)) ||
                (slot_end && (CMP_W'(cfg.read_sample_us) > cnt_ext)))) begin
              shift_smp = {item.line_level, shift_r[7:1]};
            end
            shift_nxt = shift_smp;
            if (slot_end) begin
              if (!reading_r) shift_nxt = {1'b0, shift_r[7:1]};
              bits_nxt = bits_dec;
              cnt_nxt  = '0;
              if (bits_dec == 4'd0) begin
                phase_nxt = PH_IDLE;
                drive_nxt = 1'b0;
                done      = 1'b1;
                if (reading_r) rdval_nxt = shift_smp;
              end else begin
                drive_nxt = 1'b1;
              end
            end
          end
        endcase
      end
    end else if (phase_r != PH_IDLE) begin
      rej = 1'b1;
    end else begin
      cnt_nxt   = '0;
      drive_nxt = 1'b1;
      if (item.op == OP_RESET) begin
        phase_nxt = PH_RST_LOW;
      end else begin
        phase_nxt   = PH_SLOT;
        bits_nxt    = BITS_PER_BYTE;
        reading_nxt = (item.op == OP_READ);
        shift_nxt   = (item.op == OP_WRITE) ? item.data_byte : 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      cnt_r      <= '0;
      bits_r     <= '0;
      shift_r    <= '0;
      reading_r  <= 1'b0;
      presence_r <= 1'b0;
      drive_r    <= 1'b0;
      rdval_r    <= '0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      bits_r     <= bits_nxt;
      shift_r    <= shift_nxt;
      reading_r  <= reading_nxt;
      presence_r <= presence_nxt;
      drive_r    <= drive_nxt;
      rdval_r    <= rdval_nxt;
    end
  end

  assign result.drive_low = drive_nxt;
  assign result.busy_res  = (phase_nxt != PH_IDLE);
  assign result.done_res  = done;
  assign result.presence  = presence_nxt;
  assign result.read_data = rdval_nxt;
  assign result.rejected  = rej;

  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> !drive_r)
    else $error("bus driven low while idle");

  a_slot_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SLOT) |-> ((bits_r != 4'd0) && (bits_r <= BITS_PER_BYTE)))
    else $error("bit count out of range in a slot");

  a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && rej) |=> ((phase_r == $past(phase_r)) && (cnt_r == $past(cnt_r))))
    else $error("rejected command changed state");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && done) |=> (phase_r == PH_IDLE))
    else $error("finished operation did not return to idle");

endmodule

/* hw/rtl/one_wire_bus_master.sv */
// 1-wire bus master at standard speed, paced by microsecond tick items.
// every accepted item gives exactly one result: a
// command (reset with presence detect, byte write, byte read, lsb first)
// starts an operation, a tick advances it by one microsecond, and the result
// carries the pin drive wanted for the coming microsecond plus busy, done,
// presence, last read byte and a reject flag for a command given while busy.
// throughput is one item per clock while the result side does not stall; an
// item passes from the input register through the sequencer update into
// the result register. timing registers are written through
// the cfg port, which is always ready; write them only while no operation
// is in flight and no result is pending.
module one_wire_bus_master #(
  parameter int unsigned COUNT_WIDTH = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // item input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  owbm_pkg::owbm_in_t                in_data,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output owbm_pkg::owbm_out_t               out_data,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [owbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [owbm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import owbm_pkg::*;

  owbm_cfg_t cfg;
  owbm_out_t result;

  // input register
  logic     in_valid_r;
  owbm_in_t in_data_r;
  // result register
  logic      out_valid_r;
  owbm_out_t out_data_r;

  logic out_free;
  logic step;
  logic in_xfer;

  // result slot is free when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;
  // sequencer steps on the held item when its result can be stored
  assign step     = in_valid_r && out_free;
  // input register can take a new item when empty or moving on
  assign in_stall = in_valid_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  assign cfg_ready = 1'b1;

  owbm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  owbm_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step),
    .item    (in_data_r),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) in_data_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* tb/sv/tb_one_wire_bus_master.sv */
`timescale 1ns / 1ps

module tb_one_wire_bus_master;
  import owbm_pkg::*;

  localparam int unsigned            COUNT_WIDTH   = 10;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX     = '1;
  // random part stops once this many items were sent in total
  localparam int unsigned            ITEM_TARGET   = 1050;
  localparam int unsigned            PHASE_ITEMS   = 100;
  // cycles without any transfer before the run is called hung
  localparam int unsigned            STALL_LIMIT   = 1000;
  // pause after the last result before touching the timing registers
  localparam int unsigned            SETTLE_CYCLES = 4;
  localparam int unsigned            LVL_LOW       = 0;
  localparam int unsigned            LVL_HIGH      = 1;
  localparam int unsigned            LVL_RANDOM    = 2;

  // shadow copy of the bus master: tracks its state per accepted item
  // and keeps the results it owes, oldest first
  class master_shadow;
    owbm_cfg_t              timing;
    logic [2:0]             phase;
    logic [COUNT_WIDTH-1:0] us_count;
    logic [3:0]             bits_left;
    logic [7:0]             shifter;
    logic                   reading;
    logic                   present;
    logic                   drive;
    logic [7:0]             last_read;
    owbm_out_t              replies_due[$];
    int unsigned            errors;
    int unsigned            replies;
    int unsigned            items;
    int unsigned            refused;
    int unsigned            started[4];

    function new();
      timing.reset_low_us       = RST_RESET_LOW;
      timing.presence_sample_us = RST_PRESENCE_SAMPLE;
      timing.reset_tail_us      = RST_RESET_TAIL;
      timing.short_low_us       = RST_SHORT_LOW;
      timing.long_low_us        = RST_LONG_LOW;
      timing.read_sample_us     = RST_READ_SAMPLE;
      timing.slot_length_us     = RST_SLOT_LENGTH;
      phase     = PH_IDLE;
      us_count  = '0;
      bits_left = '0;
      shifter   = '0;
      reading   = 1'b0;
      present   = 1'b0;
      drive     = 1'b0;
      last_read = '0;
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    function void set_reg(logic [2:0] idx, logic [9:0] val);
      case (idx)
        REG_RESET_LOW:       timing.reset_low_us       = val;
        REG_PRESENCE_SAMPLE: timing.presence_sample_us = val;
        REG_RESET_TAIL:      timing.reset_tail_us      = val;
        REG_SHORT_LOW:       timing.short_low_us       = val[7:0];
        REG_LONG_LOW:        timing.long_low_us        = val[7:0];
        REG_READ_SAMPLE:     timing.read_sample_us     = val[7:0];
        REG_SLOT_LENGTH:     timing.slot_length_us     = val[7:0];
        default: ;
      endcase
    endfunction

    // a phase ends at its threshold or when the counter is pinned at max
    function bit reached(int unsigned limit);
      return (32'(us_count) >= limit) || (us_count == COUNT_MAX);
    endfunction

    // one microsecond; returns 1 when the running operation finishes
    function logic advance(logic lvl);
      logic [7:0] low_time;
      logic       slot_end;
      if (phase == PH_IDLE) begin
        drive = 1'b0;
        return 1'b0;
      end
      if (us_count != COUNT_MAX) us_count++;
      case (phase)
        PH_RST_LOW: if (reached(32'(timing.reset_low_us))) begin
          drive    = 1'b0;
          us_count = '0;
          phase    = PH_RST_WAIT;
        end
        PH_RST_WAIT: if (reached(32'(timing.presence_sample_us))) begin
          present  = ~lvl;
          us_count = '0;
          phase    = PH_RST_TAIL;
        end
        PH_RST_TAIL: if (reached(32'(timing.reset_tail_us))) begin
          phase    = PH_IDLE;
          us_count = '0;
          return 1'b1;
        end
        default: begin
          low_time = (reading || shifter[0]) ? timing.short_low_us : timing.long_low_us;
          slot_end = reached(32'(timing.slot_length_us));
          drive    = (32'(us_count) < 32'(low_time));
          // a sample point past the slot end is taken at the end
          if (reading && (32'(us_count) == 32'(timing.read_sample_us) ||
                          (slot_end && 32'(timing.read_sample_us) > 32'(us_count))))
            shifter = {lvl, shifter[7:1]};
          if (slot_end) begin
            if (!reading) shifter = shifter >> 1;
            bits_left--;
            us_count = '0;
            if (bits_left == 0) begin
              phase = PH_IDLE;
              drive = 1'b0;
              if (reading) last_read = shifter;
              return 1'b1;
            end
            drive = 1'b1;
          end
        end
      endcase
      return 1'b0;
    endfunction

    function void take_item(owbm_in_t it);
      owbm_out_t want;
      logic      done;
      logic      rej;
      done = 1'b0;
      rej  = 1'b0;
      items++;
      if (it.op == OP_TICK) begin
        done = advance(it.line_level);
      end else if (busy()) begin
        rej = 1'b1;
        refused++;
      end else begin
        started[it.op]++;
        us_count = '0;
        drive    = 1'b1;
        if (it.op == OP_RESET) begin
          phase = PH_RST_LOW;
        end else begin
          phase     = PH_SLOT;
          bits_left = BITS_PER_BYTE;
          reading   = (it.op == OP_READ);
          shifter   = (it.op == OP_WRITE) ? it.data_byte : 8'h00;
        end
      end
      want.drive_low = drive;
      want.busy_res  = busy();
      want.done_res  = done;
      want.presence  = present;
      want.read_data = last_read;
      want.rejected  = rej;
      replies_due.push_back(want);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        errors++;
      end
    endfunction

    function void match_reply(owbm_out_t got);
      owbm_out_t want;
      replies++;
      if (replies_due.size() == 0) begin
        $error("result %h arrived with nothing outstanding", got);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      check_field("drive_low", 8'(want.drive_low), 8'(got.drive_low));
      check_field("busy_res",  8'(want.busy_res),  8'(got.busy_res));
      check_field("done_res",  8'(want.done_res),  8'(got.done_res));
      check_field("presence",  8'(want.presence),  8'(got.presence));
      check_field("read_data", want.read_data,     got.read_data);
      check_field("rejected",  8'(want.rejected),  8'(got.rejected));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  owbm_in_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  owbm_out_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  master_shadow shadow = new();
  bit           no_idle = 1'b0;      // set for stretches with back-to-back transfers
  int unsigned  stall_left = 0;
  int unsigned  replies_paced = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  settings = 1;        // power-up timing counts as one

  one_wire_bus_master #(.COUNT_WIDTH(COUNT_WIDTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // result side: check every transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) shadow.match_reply(out_data);
  end

  // receiver pacing: a fresh random stall after each result transfer, none while no_idle is set
  always @(negedge clk) begin
    if (shadow.replies != replies_paced) begin
      replies_paced = shadow.replies;
      stall_left = no_idle ? 0 : $urandom_range(0, 4);
    end
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // hang detection: no transfer on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // one item transfer; called at a falling edge, returns at a falling edge.
  // valid is lowered only when a gap is drawn, so it never toggles in one step
  task automatic send_item(owbm_in_t it);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.take_item(it);
    @(negedge clk);
  endtask

  task automatic issue(logic [1:0] op, logic [7:0] data, int unsigned level);
    owbm_in_t it;
    it.op         = op;
    it.data_byte  = data;
    it.line_level = (level == LVL_RANDOM) ? 1'($urandom_range(0, 1)) : level[0];
    send_item(it);
  endtask

  // keep ticking until the shadow says the operation has finished
  task automatic tick_until_idle(int unsigned level);
    while (shadow.busy()) issue(OP_TICK, 8'($urandom_range(0, 255)), level);
  endtask

  task automatic run_op(logic [1:0] op, logic [7:0] data, int unsigned level);
    issue(op, data, level);
    tick_until_idle(level);
  endtask

  // sender holds off until every owed result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (shadow.replies_due.size() != 0);
  endtask

  task automatic settle();
    tick_until_idle(LVL_RANDOM);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow.set_reg(idx, val);
    @(negedge clk);
  endtask

  // registers only change with the bus idle and nothing in flight
  task automatic program_timing(owbm_cfg_t c);
    settle();
    write_reg(REG_RESET_LOW,       c.reset_low_us);
    write_reg(REG_PRESENCE_SAMPLE, c.presence_sample_us);
    write_reg(REG_RESET_TAIL,      c.reset_tail_us);
    write_reg(REG_SHORT_LOW,       10'(c.short_low_us));
    write_reg(REG_LONG_LOW,        10'(c.long_low_us));
    write_reg(REG_READ_SAMPLE,     10'(c.read_sample_us));
    write_reg(REG_SLOT_LENGTH,     10'(c.slot_length_us));
    cfg_valid <= 1'b0;
    settings++;
  endtask

  function automatic owbm_cfg_t make_timing(int unsigned rl, int unsigned ps, int unsigned rt,
                                            int unsigned sl, int unsigned ll, int unsigned rs,
                                            int unsigned sw);
    owbm_cfg_t c;
    c.reset_low_us       = 10'(rl);
    c.presence_sample_us = 10'(ps);
    c.reset_tail_us      = 10'(rt);
    c.short_low_us       = 8'(sl);
    c.long_low_us        = 8'(ll);
    c.read_sample_us     = 8'(rs);
    c.slot_length_us     = 8'(sw);
    return c;
  endfunction

  // mostly well formed: commands on an idle bus, ticks while busy,
  // with a few commands thrown in mid-operation and some idle ticks
  function automatic owbm_in_t make_item(bit busy_now);
    owbm_in_t    it;
    int unsigned roll;
    roll          = $urandom_range(0, 99);
    it.data_byte  = 8'($urandom_range(0, 255));
    it.line_level = 1'($urandom_range(0, 1));
    it.op         = OP_TICK;
    if (busy_now ? (roll < 5) : (roll < 55)) begin
      case ($urandom_range(0, 2))
        0:       it.op = OP_RESET;
        1:       it.op = OP_WRITE;
        default: it.op = OP_READ;
      endcase
    end
    return it;
  endfunction

  initial begin
    owbm_in_t    it;
    bit          busy_now;
    int unsigned phase_items;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // short timing: idle tick, refused commands, presence absent, byte extremes
    program_timing(make_timing(4, 3, 3, 2, 5, 3, 7));
    issue(OP_TICK, 8'hFF, LVL_LOW);
    issue(OP_RESET, 8'h00, LVL_HIGH);
    issue(OP_WRITE, 8'hFF, LVL_HIGH);
    issue(OP_READ,  8'h00, LVL_HIGH);
    issue(OP_RESET, 8'h00, LVL_HIGH);
    tick_until_idle(LVL_HIGH);
    run_op(OP_WRITE, 8'h00, LVL_RANDOM);
    run_op(OP_WRITE, 8'hFF, LVL_RANDOM);
    run_op(OP_READ,  8'h00, LVL_HIGH);
    run_op(OP_READ,  8'h00, LVL_LOW);
    run_op(OP_READ,  8'h00, LVL_RANDOM);

    // zero thresholds: every phase lasts a single tick
    program_timing(make_timing(0, 0, 0, 0, 0, 0, 0));
    run_op(OP_RESET, 8'h00, LVL_LOW);
    run_op(OP_WRITE, 8'h96, LVL_RANDOM);
    run_op(OP_READ,  8'h00, LVL_RANDOM);

    // low time past the slot end and a read sample point beyond it
    program_timing(make_timing(2, 2, 2, 9, 12, 20, 8));
    run_op(OP_WRITE, 8'h3C, LVL_RANDOM);
    run_op(OP_READ,  8'h00, LVL_RANDOM);

    // full-width low times and sample point against a short slot
    program_timing(make_timing(1023, 1023, 1023, 255, 255, 255, 3));
    run_op(OP_WRITE, 8'h81, LVL_RANDOM);
    run_op(OP_READ,  8'h00, LVL_RANDOM);

    // smallest legal values
    program_timing(make_timing(1, 1, 1, 1, 1, 1, 1));
    run_op(OP_RESET, 8'h00, LVL_HIGH);
    run_op(OP_WRITE, 8'h5A, LVL_RANDOM);
    run_op(OP_READ,  8'h00, LVL_RANDOM);

    // random part: short random timings per phase, some phases with no idling
    while (shadow.items < ITEM_TARGET) begin
      program_timing(make_timing($urandom_range(0, 12), $urandom_range(0, 8),
                                 $urandom_range(0, 8), $urandom_range(0, 6),
                                 $urandom_range(0, 10), $urandom_range(0, 10),
                                 $urandom_range(0, 10)));
      no_idle     = ($urandom_range(0, 3) == 0);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS && shadow.items < ITEM_TARGET) begin
        busy_now = shadow.busy();
        it       = make_item(busy_now);
        send_item(it);
        phase_items++;
        if ($urandom_range(0, 99) == 0) wait_drained();
      end
    end
    no_idle = 1'b0;
    settle();
    repeat (10) @(posedge clk);

    $display("%0d items and %0d results checked over %0d timing settings, %0d commands refused",
             shadow.items, shadow.replies, settings, shadow.refused);
    $display("started %0d bus resets, %0d byte writes and %0d byte reads",
             shadow.started[OP_RESET], shadow.started[OP_WRITE], shadow.started[OP_READ]);
    if (shadow.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
